@@ design/iaee_pkg.sv @@
// Shared types and constants for the infix arithmetic expression evaluator.
// Holds the operator codes, the ASCII codes, the front-to-back command and the result record.
// No dependencies.
package iaee_pkg;

  // Operator codes, in the order the add/sub/mul/div pending operator uses
  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  // ASCII codes the front decodes
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // Radix-2 divider steps for a 32-bit quotient
  localparam int unsigned DivSteps = 32;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BkIdle,
    BkMul,
    BkMulWb,
    BkDiv,
    BkDivWb,
    BkFinish
  } bk_state_e;

  // Classified byte handed from front to back
  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
    logic       is_op;
    op_e        op;
    logic       last;
  } cmd_t;

  // Finished expression result
  typedef struct packed {
    logic signed [31:0] value;
    logic               div_zero;
  } res_t;

endpackage

@@ design/iaee_front.sv @@
// Front end: classifies incoming ASCII bytes and queues them as commands.
// Depends on iaee_pkg (cmd_t, op_e, character codes).
module iaee_front #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  input  logic [7:0]    char_in_i,
  input  logic          is_last_i,
  output logic          full,
  output logic          cmd_valid_o,
  output iaee_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import iaee_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            cmd_mem [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  cmd_t       cmd_new;
  logic [7:0] digit_diff;
  logic       wr_en;

  // Decode the byte into digit / operator / last
  always_comb begin
    cmd_new          = '0;
    digit_diff       = char_in_i - CharZero;
    cmd_new.is_digit = char_in_i inside {[CharZero:CharNine]};
    cmd_new.digit    = digit_diff[3:0];
    cmd_new.last     = is_last_i;
    cmd_new.is_op    = 1'b1;
    case (char_in_i)
      CharPlus:  cmd_new.op = OpAdd;
      CharMinus: cmd_new.op = OpSub;
      CharStar:  cmd_new.op = OpMul;
      CharSlash: cmd_new.op = OpDiv;
      default: begin
        cmd_new.op    = OpAdd;
        cmd_new.is_op = 1'b0;
      end
    endcase
  end

  assign full = (cnt_q == CntW'(Depth));

  // Drop bytes that neither build a number, carry an operator nor end the expression
  assign wr_en = push && !full && (cmd_new.is_digit || cmd_new.is_op || cmd_new.last);

  // Advance pointers and occupancy
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_en) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (cmd_pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    case ({wr_en, cmd_pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the command
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cmd_mem[wptr_q] <= cmd_new;
    end
  end

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cmd_mem[rptr_q];

endmodule

@@ design/iaee_back.sv @@
// Back end: executes queued commands against the sum / last-term state.
// Uses a registered multiplier and a 32-step radix-2 divider. Depends on iaee_pkg.
module iaee_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  iaee_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           res_valid_o,
  output iaee_pkg::res_t res_o,
  input  logic           res_ready_i
);
  import iaee_pkg::*;

  bk_state_e state_q, state_d;

  // Expression state
  logic [31:0] acc_q, acc_d;
  op_e         op_q, op_d;
  logic [31:0] sum_q, sum_d;
  logic [31:0] term_q, term_d;
  logic        err_q, err_d;

  // Datapath working registers
  logic               last_q, last_d;
  logic [31:0]        opnd_q, opnd_d;
  logic [31:0]        prod_q, prod_d;
  logic [31:0]        rem_q, rem_d;
  logic [31:0]        quo_q, quo_d;
  logic [31:0]        dvs_q, dvs_d;
  logic               neg_q, neg_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  logic [31:0] acc_new;
  logic [31:0] prod_full;
  logic [32:0] rem_sh;
  logic [32:0] rem_diff;

  // Fold the digit in: acc * 10 + digit
  assign acc_new = cmd_i.is_digit ? ((acc_q << 3) + (acc_q << 1) + {28'd0, cmd_i.digit})
                                  : acc_q;

  assign prod_full = term_q * opnd_q;
  assign rem_sh    = {rem_q, quo_q[31]};
  assign rem_diff  = rem_sh - {1'b0, dvs_q};

  // Sequencer
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    op_d        = op_q;
    sum_d       = sum_q;
    term_d      = term_q;
    err_d       = err_q;
    last_d      = last_q;
    opnd_d      = opnd_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dvs_d       = dvs_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    cmd_pop_o   = 1'b0;
    res_valid_o = 1'b0;
    res_o.value    = sum_q + term_q;
    res_o.div_zero = err_q;
    case (state_q)
      BkIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          last_d    = cmd_i.last;
          if (cmd_i.is_op || cmd_i.last) begin
            acc_d = '0;
            if (cmd_i.is_op) begin
              op_d = cmd_i.op;
            end
            case (op_q)
              OpAdd: begin
                sum_d   = sum_q + term_q;
                term_d  = acc_new;
                state_d = cmd_i.last ? BkFinish : BkIdle;
              end
              OpSub: begin
                sum_d   = sum_q + term_q;
                term_d  = 32'd0 - acc_new;
                state_d = cmd_i.last ? BkFinish : BkIdle;
              end
              OpMul: begin
                opnd_d  = acc_new;
                state_d = BkMul;
              end
              default: begin
                if (acc_new == '0) begin
                  term_d  = '0;
                  err_d   = 1'b1;
                  state_d = cmd_i.last ? BkFinish : BkIdle;
                end else begin
                  quo_d   = term_q[31] ? 32'd0 - term_q : term_q;
                  dvs_d   = acc_new[31] ? 32'd0 - acc_new : acc_new;
                  neg_d   = term_q[31] ^ acc_new[31];
                  rem_d   = '0;
                  cnt_d   = '0;
                  state_d = BkDiv;
                end
              end
            endcase
          end else begin
            acc_d = acc_new;
          end
        end
      end
      BkMul: begin
        prod_d  = prod_full;
        state_d = BkMulWb;
      end
      BkMulWb: begin
        term_d  = prod_q;
        state_d = last_q ? BkFinish : BkIdle;
      end
      BkDiv: begin
        // One restoring step: shift in a dividend bit, subtract if it fits
        if (!rem_diff[32]) begin
          rem_d = rem_diff[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = rem_sh[31:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = BkDivWb;
        end
      end
      BkDivWb: begin
        term_d  = neg_q ? 32'd0 - quo_q : quo_q;
        state_d = last_q ? BkFinish : BkIdle;
      end
      BkFinish: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          acc_d   = '0;
          op_d    = OpAdd;
          sum_d   = '0;
          term_d  = '0;
          err_d   = 1'b0;
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      acc_q   <= '0;
      op_q    <= OpAdd;
      sum_q   <= '0;
      term_q  <= '0;
      err_q   <= 1'b0;
      last_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      op_q    <= op_d;
      sum_q   <= sum_d;
      term_q  <= term_d;
      err_q   <= err_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
    end
  end

  // Hold datapath operands
  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
  end

endmodule

@@ design/infix_arith_expression_evaluator.sv @@
// Top level of the infix arithmetic expression evaluator.
// Instantiates iaee_front and iaee_back and holds the result register; uses iaee_pkg.
//
// Bytes of an expression are pushed one per transfer; the byte with is_last_i set closes
// the expression and one result (value_o, div_zero_o) appears on the result side. The front
// queue holds QueueDepth classified bytes, so pushes continue while the back end is busy;
// bytes that are neither digits nor operators and do not end an expression are dropped at
// the front and cost no back-end time. The back end takes a digit or a byte that applies
// + or - in its idle state; one that applies * goes on through the multiply and write-back
// states, and one that applies / through a 32-step radix-2 divider plus setup and sign
// correction, which sets the worst-case sustained spacing. The closing byte then forms the
// sum in a finish state, where the back end waits while the result register is still full.
module infix_arith_expression_evaluator #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_in_i,
  input  logic               is_last_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] value_o,
  output logic               div_zero_o
);
  import iaee_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res;
  logic res_valid;
  logic res_ready;

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] value_q;
  logic               div_zero_q;

  iaee_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .char_in_i  (char_in_i),
    .is_last_i  (is_last_i),
    .full       (full),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  iaee_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  // Result register: load when empty or being drained this cycle
  assign res_ready = !out_valid_q || pop;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      value_q    <= res.value;
      div_zero_q <= res.div_zero;
    end
  end

  assign empty      = !out_valid_q;
  assign value_o    = value_q;
  assign div_zero_o = div_zero_q;

  // The back end only drains a command that is actually queued
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

  // A result handed over is visible in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (res_valid && res_ready) |=> out_valid_q)
    else $error("result transfer lost");

  // A waiting result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !pop) |=> (out_valid_q && $stable(value_q)
                                              && $stable(div_zero_q)))
    else $error("waiting result changed");

endmodule

@@ verif/iaee_eval_checker.sv @@
// Checker for the infix arithmetic expression evaluator: watches both queue ports,
// folds every accepted byte into its own evaluation state and compares each popped result.
// Depends on iaee_pkg for the operator codes, ASCII codes and the result record.
module iaee_eval_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic               full,
  input  logic [7:0]         char_in_i,
  input  logic               is_last_i,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [31:0] value_o,
  input  logic               div_zero_o,
  output int unsigned        err_count_o,
  output int unsigned        owed_count_o
);
  import iaee_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] Radix = 32'd10;

  // Evaluation state: number being read, operator before it, finished sum, open term
  typedef struct packed {
    logic [31:0] num;
    op_e         op;
    logic [31:0] sum;
    logic [31:0] term;
    logic        err;
  } calc_t;

  localparam calc_t CalcIdle = '{num: '0, op: OpAdd, sum: '0, term: '0, err: 1'b0};

  calc_t       calc;
  res_t        owed_q[$];
  res_t        want;
  int unsigned errs;

  // Signed 32-bit division truncating toward zero; -2^31 / -1 wraps back to -2^31
  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? 32'd0 - a : a;
    mb = b[31] ? 32'd0 - b : b;
    q  = ma / mb;
    return (a[31] ^ b[31]) ? 32'd0 - q : q;
  endfunction

  // Apply the pending operator to the number just read and clear the number
  function automatic calc_t close_number(calc_t s);
    case (s.op)
      OpAdd: begin
        s.sum  = s.sum + s.term;
        s.term = s.num;
      end
      OpSub: begin
        s.sum  = s.sum + s.term;
        s.term = 32'd0 - s.num;
      end
      OpMul: s.term = s.term * s.num;
      default: begin
        if (s.num == 32'd0) begin
          s.term = 32'd0;
          s.err  = 1'b1;
        end else begin
          s.term = div_trunc(s.term, s.num);
        end
      end
    endcase
    s.num = 32'd0;
    return s;
  endfunction

  // Fold one accepted byte; a closing byte queues the value the block owes
  task automatic take_byte(input logic [7:0] c, input logic last);
    logic is_op;
    op_e  op;
    is_op = 1'b1;
    op    = OpAdd;
    case (c)
      CharPlus:  op = OpAdd;
      CharMinus: op = OpSub;
      CharStar:  op = OpMul;
      CharSlash: op = OpDiv;
      default:   is_op = 1'b0;
    endcase
    if (c >= CharZero && c <= CharNine) begin
      calc.num = calc.num * Radix + {24'd0, c - CharZero};
    end
    if (is_op || last) begin
      calc = close_number(calc);
      if (is_op) begin
        calc.op = op;
      end
    end
    if (last) begin
      owed_q.push_back('{value: calc.sum + calc.term, div_zero: calc.err});
      calc = CalcIdle;
    end
  endtask

  // Compare on pop, predict on push; counts leave through nonblocking updates
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calc = CalcIdle;
      owed_q.delete();
      errs = 0;
    end else begin
      if (pop && !empty) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result: value %0d div_zero %0b", value_o, div_zero_o);
          errs++;
        end else begin
          want = owed_q.pop_front();
          if (value_o !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value_o);
            errs++;
          end
          if (div_zero_o !== want.div_zero) begin
            $error("div_zero: expected %0b, got %0b", want.div_zero, div_zero_o);
            errs++;
          end
        end
      end
      if (push && !full) begin
        take_byte(char_in_i, is_last_i);
      end
    end
    err_count_o  <= errs;
    owed_count_o <= owed_q.size();
  end

endmodule

@@ verif/infix_arith_expression_evaluator_tb.sv @@
// Testbench top for the infix arithmetic expression evaluator: clock, reset, byte stimulus,
// result popping with random stalls, and the verdict.
// Depends on iaee_pkg, infix_arith_expression_evaluator and iaee_eval_checker.
module infix_arith_expression_evaluator_tb;
  import iaee_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  CharSpace   = 8'h20;
  localparam int unsigned ByteTarget  = 1400;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 80;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               push      = 1'b0;
  logic               full;
  logic [7:0]         char_in_i = 8'h00;
  logic               is_last_i = 1'b0;
  logic               empty;
  logic               pop       = 1'b0;
  logic signed [31:0] value_o;
  logic               div_zero_o;
  int unsigned        err_count;
  int unsigned        owed_count;

  logic               calm      = 1'b0;
  logic               hold_go   = 1'b0;
  int unsigned        taken     = 0;
  logic [7:0]         expr_q[$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  infix_arith_expression_evaluator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .char_in_i  (char_in_i),
    .is_last_i  (is_last_i),
    .empty      (empty),
    .pop        (pop),
    .value_o    (value_o),
    .div_zero_o (div_zero_o)
  );

  iaee_eval_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .char_in_i    (char_in_i),
    .is_last_i    (is_last_i),
    .empty        (empty),
    .pop          (pop),
    .value_o      (value_o),
    .div_zero_o   (div_zero_o),
    .err_count_o  (err_count),
    .owed_count_o (owed_count)
  );

  function automatic logic [7:0] op_char(int unsigned k);
    case (k)
      0:       return CharPlus;
      1:       return CharMinus;
      2:       return CharStar;
      default: return CharSlash;
    endcase
  endfunction

  // Offer one byte, with a random gap first, and hold it until the transfer
  task automatic send_byte(input logic [7:0] c, input logic last);
    while (!calm && $urandom_range(99) < 12) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    char_in_i <= c;
    is_last_i <= last;
    do @(posedge clk_i); while (full);
    taken++;
  endtask

  // Send a whole text, closing the expression on its final byte
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
  endtask

  // Build one expression: mostly well-formed with random numbers, sometimes broken or noise
  task automatic build_expr();
    int unsigned kind, n_terms, n_digits, pick;
    logic [7:0]  op_c;
    logic        op_used;
    expr_q.delete();
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(8, 1)) expr_q.push_back(8'($urandom_range(255)));
    end else begin
      n_terms = $urandom_range(6, 1);
      for (int t = 0; t < n_terms; t++) begin
        op_c    = op_char($urandom_range(3));
        op_used = (t != 0) || ($urandom_range(99) < 5);
        if (op_used) begin
          if ($urandom_range(99) < 20) expr_q.push_back(CharSpace);
          // a doubled operator now and then breaks the sequence
          if ($urandom_range(99) < 5) expr_q.push_back(op_char($urandom_range(3)));
          expr_q.push_back(op_c);
          if ($urandom_range(99) < 20) expr_q.push_back(CharSpace);
        end
        if (op_used && op_c == CharSlash && $urandom_range(99) < 10) begin
          expr_q.push_back(CharZero);
        end else begin
          pick     = $urandom_range(99);
          n_digits = (pick < 85) ? $urandom_range(3, 1) :
                     (pick < 95) ? $urandom_range(9, 4) : $urandom_range(12, 10);
          repeat (n_digits) expr_q.push_back(CharZero + 8'($urandom_range(9)));
        end
        if ($urandom_range(99) < 4) expr_q.push_back(8'($urandom_range(255)));
      end
      // trailing blank or operator on the closing byte
      if ($urandom_range(99) < 8) begin
        expr_q.push_back($urandom_range(1) ? CharSpace : op_char($urandom_range(3)));
      end
    end
  endtask

  // Pop results; idle at random, hold off once for a long stretch
  initial begin : pop_side
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= calm || ($urandom_range(99) >= 12);
      end
    end
  end

  // Abort a run that hangs
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    bit hold_sent;
    hold_sent = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Blank expression, stray bytes, division by zero, overflowing division, long numbers
    send_text(" ");
    send_byte(8'hFF, 1'b0);
    send_text("9/0");
    send_text("-2147483648/4294967295");
    // Operator on the closing byte, with a NUL byte ignored up front
    send_byte(8'h00, 1'b0);
    send_text("1+6*7-");

    // Random expressions
    while (taken < ByteTarget) begin
      if (!hold_sent && taken > 300) begin
        hold_go   <= 1'b1;
        hold_sent = 1'b1;
      end
      calm <= (taken >= 700 && taken < 950);
      build_expr();
      for (int i = 0; i < expr_q.size(); i++) begin
        send_byte(expr_q[i], i == expr_q.size() - 1);
      end
    end
    push <= 1'b0;
    calm <= 1'b0;

    // Let the owed count catch up with the last transfer, then drain outstanding results
    @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0 && owed_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ infix_arith_expression_evaluator.f @@
design/iaee_pkg.sv
design/iaee_front.sv
design/iaee_back.sv
design/infix_arith_expression_evaluator.sv
verif/iaee_eval_checker.sv
verif/infix_arith_expression_evaluator_tb.sv
